[src/assert_macros.svh]
// Assertion helpers used by the checker file amsfl_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define AMSFL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("amsfl assertion failed");

// Clocked assertion that also holds across reset.
`define AMSFL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("amsfl assertion failed");

`endif

[src/amsfl_pkg.sv]
package amsfl_pkg;

   localparam int MEM_AW    = 16;
   localparam int MEM_WORDS = 1 << MEM_AW;
   localparam int QD        = 8;
   localparam int QAW       = 3;
   localparam int QCW       = 4;
   localparam logic [7:0] LAT_MAX   = 8'd255;
   localparam logic [7:0] LAT_RESET = 8'd8;

   typedef struct packed {
      logic              en;
      logic [3:0]        be;
      logic [MEM_AW-1:0] addr;
      logic [31:0]       data;
   } mem_wr_type;

   // saturating latency count
   function automatic logic [7:0] lat_sat(input logic [7:0] v);
      return (v == LAT_MAX) ? v : v + 8'd1;
   endfunction

endpackage

[src/axi_memory_slave_fixed_latency_core.sv]
// AXI4-style memory slave model with fixed response latency, one bus cycle
// per item.
// req channel: one item is the slave-side view of one bus cycle (all channel
//   valids/readies and payloads). rsp channel: one item per req item, with the
//   slave's ready/response/read-data outputs for that cycle, computed from
//   state before the cycle's update.
// Each item runs in a read step and an update step: the read step reads the
// 64K x 32 word memory at the head read burst's beat address, the update step
// applies all updates (byte-strobed write, queue pushes/pops, latency counts)
// and loads the output register. A new item is not taken until the update
// step (ST_EXEC) is done; the memory has separate read and write ports.
// Output register: a new item is taken while the register is empty or its
// result is taken. While a result waits and rsp_tready is low, req_tready stays low.
// Reset: clears queues and write state, sets response_latency to 8, and then
// sweeps the memory to zero, one word per cycle, during which req_tready is
// low. csr writes are taken at any time.
// csr_wen/csr_wdata write response_latency; write only while idle.
module axi_memory_slave_fixed_latency_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // flags[5:0], wr addr[37:6], wr id[41:38], wr size[44:42], wr data[76:45],
   // wr strobe[80:77], rd addr[112:81], rd id[116:113], rd len[124:117],
   // rd size[127:125]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // aw_ready[0], w_ready[1], b_valid[2], b_id[6:3], ar_ready[7], r_valid[8],
   // r_id[12:9], r_data[44:13], zero[47:45]
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_wen,
   input  logic [7:0]   csr_wdata
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_type;

   localparam int QD  = amsfl_pkg::QD;
   localparam int QAW = amsfl_pkg::QAW;
   localparam int QCW = amsfl_pkg::QCW;
   localparam int MAW = amsfl_pkg::MEM_AW;

   state_type state_ff, state_in;
   logic [MAW-1:0] clr_ff, clr_in;
   logic [127:0] item_ff;
   logic [7:0]   lat_cfg_ff;

   // write burst
   logic        busy_ff, busy_in;
   logic [31:0] wb_addr_ff, wb_addr_in;
   logic [3:0]  wb_id_ff, wb_id_in;
   logic [2:0]  wb_size_ff, wb_size_in;
   logic [7:0]  wb_beat_ff, wb_beat_in;

   // write response queue
   logic [3:0]     bq_id_ff [QD];
   logic [3:0]     bq_id_in [QD];
   logic [7:0]     bq_lat_ff [QD];
   logic [7:0]     bq_lat_in [QD];
   logic [QAW-1:0] bq_head_ff, bq_head_in;
   logic [QCW-1:0] bq_cnt_ff, bq_cnt_in;

   // read request queue
   logic [31:0]    rq_addr_ff [QD];
   logic [31:0]    rq_addr_in [QD];
   logic [3:0]     rq_id_ff [QD];
   logic [3:0]     rq_id_in [QD];
   logic [7:0]     rq_len_ff [QD];
   logic [7:0]     rq_len_in [QD];
   logic [2:0]     rq_size_ff [QD];
   logic [2:0]     rq_size_in [QD];
   logic [7:0]     rq_beat_ff [QD];
   logic [7:0]     rq_beat_in [QD];
   logic [7:0]     rq_lat_ff [QD];
   logic [7:0]     rq_lat_in [QD];
   logic           rq_dp_ff [QD];
   logic           rq_dp_in [QD];
   logic [QAW-1:0] rq_head_ff, rq_head_in;
   logic [QCW-1:0] rq_cnt_ff, rq_cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [44:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // item fields
   logic        aw_valid, w_valid, w_last, b_ready, ar_valid, r_ready;
   logic [31:0] in_waddr, in_wdata, in_raddr;
   logic [3:0]  in_wid, in_wstrb, in_rid;
   logic [2:0]  in_wsize, in_rsize;
   logic [7:0]  in_rlen;

   // cycle outputs and events
   logic        aw_ready, w_ready, b_valid, ar_ready, r_valid, r_last;
   logic [3:0]  b_id, r_id;
   logic [31:0] r_data, rd_byte_addr, wr_byte_addr, mem_rdata;
   logic        aw_acc, w_acc, b_pop, bq_push, ar_acc, r_acc, rq_pop, exec;
   logic [QAW-1:0] bq_tail, rq_tail, rel;
   logic [7:0]  lat_next;
   amsfl_pkg::mem_wr_type mem_wr;

   assign {in_rsize, in_rlen, in_rid, in_raddr, in_wstrb, in_wdata,
           in_wsize, in_wid, in_waddr} = item_ff[127:6];
   assign {r_ready, ar_valid, b_ready, w_last, w_valid, aw_valid} = item_ff[5:0];

   assign exec = (state_ff == ST_EXEC);

   // head read beat address, read in the cycle an item is taken
   assign rd_byte_addr = rq_addr_ff[rq_head_ff]
                       + (32'(rq_beat_ff[rq_head_ff]) << rq_size_ff[rq_head_ff]);
   assign wr_byte_addr = wb_addr_ff + (32'(wb_beat_ff) << wb_size_ff);

   // outputs from pre-update state
   assign aw_ready = !busy_ff && (bq_cnt_ff < QCW'(QD));
   assign w_ready  = busy_ff;
   assign b_valid  = (bq_cnt_ff != '0) && (bq_lat_ff[bq_head_ff] >= lat_cfg_ff);
   assign b_id     = b_valid ? bq_id_ff[bq_head_ff] : 4'd0;
   assign ar_ready = rq_cnt_ff < QCW'(QD);
   assign r_valid  = (rq_cnt_ff != '0) && rq_dp_ff[rq_head_ff];
   assign r_id     = r_valid ? rq_id_ff[rq_head_ff] : 4'd0;
   assign r_data   = r_valid ? mem_rdata : 32'd0;
   assign r_last   = r_valid && (rq_beat_ff[rq_head_ff] == rq_len_ff[rq_head_ff]);

   assign aw_acc  = aw_valid && aw_ready;
   assign w_acc   = w_valid && w_ready;
   assign b_pop   = b_valid && b_ready;
   assign bq_push = w_acc && w_last && (bq_cnt_ff < QCW'(QD));
   assign ar_acc  = ar_valid && ar_ready;
   assign r_acc   = r_valid && r_ready;
   assign rq_pop  = r_acc && r_last;
   assign bq_tail = bq_head_ff + bq_cnt_ff[QAW-1:0];
   assign rq_tail = rq_head_ff + rq_cnt_ff[QAW-1:0];

   always_comb begin
      mem_wr = '0;
      if (state_ff == ST_CLEAR) begin
         mem_wr.en   = 1'b1;
         mem_wr.be   = 4'hF;
         mem_wr.addr = clr_ff;
         mem_wr.data = 32'd0;
      end else if (exec && w_acc) begin
         mem_wr.en   = 1'b1;
         mem_wr.be   = in_wstrb;
         mem_wr.addr = wr_byte_addr[MAW+1:2];
         mem_wr.data = in_wdata;
      end
   end

   amsfl_mem u_mem (
      .clock (clock),
      .wr    (mem_wr),
      .raddr (rd_byte_addr[MAW+1:2]),
      .rdata (mem_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      busy_in      = busy_ff;
      wb_addr_in   = wb_addr_ff;
      wb_id_in     = wb_id_ff;
      wb_size_in   = wb_size_ff;
      wb_beat_in   = wb_beat_ff;
      bq_id_in     = bq_id_ff;
      bq_lat_in    = bq_lat_ff;
      bq_head_in   = bq_head_ff;
      bq_cnt_in    = bq_cnt_ff;
      rq_addr_in   = rq_addr_ff;
      rq_id_in     = rq_id_ff;
      rq_len_in    = rq_len_ff;
      rq_size_in   = rq_size_ff;
      rq_beat_in   = rq_beat_ff;
      rq_lat_in    = rq_lat_ff;
      rq_dp_in     = rq_dp_ff;
      rq_head_in   = rq_head_ff;
      rq_cnt_in    = rq_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rel          = '0;
      lat_next     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = {r_data, r_id, r_valid, ar_ready, b_id, b_valid,
                            w_ready, aw_ready};
            rsp_last_in  = r_last;

            // write channel
            if (aw_acc) begin
               busy_in    = 1'b1;
               wb_addr_in = in_waddr;
               wb_id_in   = in_wid;
               wb_size_in = in_wsize;
               wb_beat_in = 8'd0;
            end
            if (w_acc) begin
               wb_beat_in = wb_beat_ff + 8'd1;
               if (w_last) begin
                  busy_in = 1'b0;
               end
            end
            bq_head_in = bq_head_ff + QAW'(b_pop);
            bq_cnt_in  = bq_cnt_ff + QCW'(bq_push) - QCW'(b_pop);
            for (int k = 0; k < QD; k++) begin
               rel = QAW'(k) - bq_head_in;
               if (bq_push && (QAW'(k) == bq_tail)) begin
                  bq_id_in[k]  = wb_id_ff;
                  bq_lat_in[k] = amsfl_pkg::lat_sat(8'd0);
               end else if (QCW'(rel) < bq_cnt_in) begin
                  bq_lat_in[k] = amsfl_pkg::lat_sat(bq_lat_ff[k]);
               end
            end

            // read channel
            rq_head_in = rq_head_ff + QAW'(rq_pop);
            rq_cnt_in  = rq_cnt_ff + QCW'(ar_acc) - QCW'(rq_pop);
            for (int k = 0; k < QD; k++) begin
               rel = QAW'(k) - rq_head_in;
               if (ar_acc && (QAW'(k) == rq_tail)) begin
                  lat_next      = amsfl_pkg::lat_sat(8'd0);
                  rq_addr_in[k] = in_raddr;
                  rq_id_in[k]   = in_rid;
                  rq_len_in[k]  = in_rlen;
                  rq_size_in[k] = in_rsize;
                  rq_beat_in[k] = 8'd0;
                  rq_lat_in[k]  = lat_next;
                  rq_dp_in[k]   = lat_next >= lat_cfg_ff;
               end else if (QCW'(rel) < rq_cnt_in) begin
                  if (r_acc && (QAW'(k) == rq_head_ff)) begin
                     rq_beat_in[k] = rq_beat_ff[k] + 8'd1;
                  end
                  if (!rq_dp_ff[k]) begin
                     lat_next     = amsfl_pkg::lat_sat(rq_lat_ff[k]);
                     rq_lat_in[k] = lat_next;
                     rq_dp_in[k]  = lat_next >= lat_cfg_ff;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         busy_ff      <= 1'b0;
         wb_addr_ff   <= '0;
         wb_id_ff     <= '0;
         wb_size_ff   <= '0;
         wb_beat_ff   <= '0;
         bq_head_ff   <= '0;
         bq_cnt_ff    <= '0;
         rq_head_ff   <= '0;
         rq_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         busy_ff      <= busy_in;
         wb_addr_ff   <= wb_addr_in;
         wb_id_ff     <= wb_id_in;
         wb_size_ff   <= wb_size_in;
         wb_beat_ff   <= wb_beat_in;
         bq_head_ff   <= bq_head_in;
         bq_cnt_ff    <= bq_cnt_in;
         rq_head_ff   <= rq_head_in;
         rq_cnt_ff    <= rq_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_cfg_ff <= amsfl_pkg::LAT_RESET;
      end else if (csr_wen) begin
         lat_cfg_ff <= csr_wdata;
      end
   end

   // queue payload, valid only under the counts
   always_ff @(posedge clock) begin
      bq_id_in_q: begin
      end
      bq_id_ff    <= bq_id_in;
      bq_lat_ff   <= bq_lat_in;
      rq_addr_ff  <= rq_addr_in;
      rq_id_ff    <= rq_id_in;
      rq_len_ff   <= rq_len_in;
      rq_size_ff  <= rq_size_in;
      rq_beat_ff  <= rq_beat_in;
      rq_lat_ff   <= rq_lat_in;
      rq_dp_ff    <= rq_dp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[src/amsfl_mem.sv]
module amsfl_mem (
   input  logic                         clock,
   input  amsfl_pkg::mem_wr_type        wr,
   input  logic [amsfl_pkg::MEM_AW-1:0] raddr,
   output logic [31:0]                  rdata
);

   logic [3:0][7:0] mem [amsfl_pkg::MEM_WORDS];
   logic [31:0]     rdata_ff;

   // byte-lane write enables
   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (wr.en && wr.be[b]) begin
            mem[wr.addr][b] <= wr.data[8*b +: 8];
         end
      end
   end

   // read before write on the same word
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/amsfl_chk.sv]
`include "assert_macros.svh"

module amsfl_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // no result right after reset
   `AMSFL_ASSERT_ALWAYS(a_rst_idle, clock, reset |=> !rsp_tvalid)

   // an item occupies the block for its update cycle
   `AMSFL_ASSERT(a_busy_after_take, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // a stalled result holds
   `AMSFL_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // write response id reads zero without b_valid
   `AMSFL_ASSERT(a_bid_zero, clock, reset, rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[6:3] == 4'd0)

endmodule

bind axi_memory_slave_fixed_latency_core amsfl_chk u_chk (.*);
